[design/dfnps_pkg.sv]
// Shared types and constants of the depth frame nearest point statistics unit.
package dfnps_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_BOX_HALF_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_DEPTH_WINDOW     = 2'd1;
    localparam logic [1:0] CFG_OBJECT_THRESHOLD = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;

    // Reset values of the configuration registers
    localparam logic [9:0]  HALF_WIDTH_RESET = 10'd100;
    localparam logic [10:0] WINDOW_RESET     = 11'd200;
    localparam logic [16:0] THRESHOLD_RESET  = 17'd300;

    // Best depth before any point of a frame: above every 16-bit depth
    localparam logic [16:0] Z_ABOVE_ANY = 17'h10000;

    // Reported counts saturate here
    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

    // Quotient bits produced by the shared divider
    localparam int QUOT_W = 16;

    // Frame-end sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT_DEPTH,
        ST_WAIT_CONF,
        ST_EMIT
    } seq_state_t;

endpackage

[design/dfnps_div.sv]
// Shared radix-2 restoring divider, one quotient bit per cycle.
module dfnps_div #(
    parameter int CNT_W = 17
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [CNT_W+dfnps_pkg::QUOT_W-1:0] dividend,
    input  logic [CNT_W-1:0]                  divisor,
    output logic                              done,
    output logic [dfnps_pkg::QUOT_W-1:0]      quotient
);
    import dfnps_pkg::*;

    localparam int STEP_W = $clog2(QUOT_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [QUOT_W-1:0]   lo_reg, lo_next;

    logic [CNT_W:0]      trial;
    logic [CNT_W:0]      diff;
    logic                ge;

    // Upper dividend part is below the divisor since the quotient fits QUOT_W bits
    assign trial = {rem_reg, lo_reg[QUOT_W-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = dividend[CNT_W+QUOT_W-1:QUOT_W];
            lo_next   = dividend[QUOT_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            lo_next   = {lo_reg[QUOT_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(QUOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
    end

    assign done     = done_reg;
    assign quotient = lo_reg;

endmodule

[design/dfnps_accum.sv]
// Per-frame accumulator: sums, nearest point, box test and reference point.
module dfnps_accum #(
    parameter int MAX_FRAME_POINTS = 65536,
    parameter int CNT_W            = 17
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic               clear,
    input  logic signed [15:0] point_x,
    input  logic signed [15:0] point_y,
    input  logic [15:0]        point_z,
    input  logic [7:0]         point_confidence,
    input  logic [9:0]         box_half_width,
    input  logic [10:0]        depth_window,
    output logic signed [15:0] best_x,
    output logic signed [15:0] best_y,
    output logic [15:0]        best_z,
    output logic [CNT_W+15:0]  depth_sum,
    output logic [CNT_W+7:0]   confidence_sum,
    output logic [CNT_W-1:0]   points_seen,
    output logic [CNT_W-1:0]   inside_count
);
    import dfnps_pkg::*;

    logic signed [15:0] prev_x_reg, prev_x_next;
    logic signed [15:0] prev_y_reg, prev_y_next;
    logic [15:0]        prev_z_reg, prev_z_next;
    logic signed [15:0] best_x_reg, best_x_next;
    logic signed [15:0] best_y_reg, best_y_next;
    logic [16:0]        best_z_reg, best_z_next;
    logic [CNT_W+15:0]  dsum_reg, dsum_next;
    logic [CNT_W+7:0]   csum_reg, csum_next;
    logic [CNT_W-1:0]   seen_reg, seen_next;
    logic [CNT_W-1:0]   inside_reg, inside_next;

    logic               room;
    logic signed [17:0] x_lo, x_hi, y_lo, y_hi, xs, ys;
    logic [16:0]        z_hi;
    logic               in_box;

    assign room = seen_reg < CNT_W'(MAX_FRAME_POINTS);

    // Box bounds, exclusive on both sides
    assign xs   = 18'(point_x);
    assign ys   = 18'(point_y);
    assign x_lo = 18'(prev_x_reg) - $signed({8'd0, box_half_width});
    assign x_hi = 18'(prev_x_reg) + $signed({8'd0, box_half_width});
    assign y_lo = 18'(prev_y_reg) - $signed({8'd0, box_half_width});
    assign y_hi = 18'(prev_y_reg) + $signed({8'd0, box_half_width});
    assign z_hi = {1'b0, prev_z_reg} + {6'd0, depth_window};

    assign in_box = (xs > x_lo) && (xs < x_hi) && (ys > y_lo) && (ys < y_hi) &&
                    (point_z > prev_z_reg) && ({1'b0, point_z} < z_hi);

    always_comb
    begin
        prev_x_next = prev_x_reg;
        prev_y_next = prev_y_reg;
        prev_z_next = prev_z_reg;
        best_x_next = best_x_reg;
        best_y_next = best_y_reg;
        best_z_next = best_z_reg;
        dsum_next   = dsum_reg;
        csum_next   = csum_reg;
        seen_next   = seen_reg;
        inside_next = inside_reg;
        if (clear)
        begin
            // Nearest point of the closed frame becomes the next reference
            prev_x_next = best_x_reg;
            prev_y_next = best_y_reg;
            prev_z_next = best_z_reg[15:0];
            best_x_next = '0;
            best_y_next = '0;
            best_z_next = Z_ABOVE_ANY;
            dsum_next   = '0;
            csum_next   = '0;
            seen_next   = '0;
            inside_next = '0;
        end
        else if (take && room)
        begin
            if (in_box)
                inside_next = inside_reg + 1'b1;
            dsum_next = dsum_reg + (CNT_W+16)'(point_z);
            csum_next = csum_reg + (CNT_W+8)'(point_confidence);
            if ({1'b0, point_z} < best_z_reg)
            begin
                best_x_next = point_x;
                best_y_next = point_y;
                best_z_next = {1'b0, point_z};
            end
            seen_next = seen_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            prev_z_reg <= '0;
            best_x_reg <= '0;
            best_y_reg <= '0;
            best_z_reg <= Z_ABOVE_ANY;
            dsum_reg   <= '0;
            csum_reg   <= '0;
            seen_reg   <= '0;
            inside_reg <= '0;
        end
        else
        begin
            prev_x_reg <= prev_x_next;
            prev_y_reg <= prev_y_next;
            prev_z_reg <= prev_z_next;
            best_x_reg <= best_x_next;
            best_y_reg <= best_y_next;
            best_z_reg <= best_z_next;
            dsum_reg   <= dsum_next;
            csum_reg   <= csum_next;
            seen_reg   <= seen_next;
            inside_reg <= inside_next;
        end
    end

    assign best_x         = best_x_reg;
    assign best_y         = best_y_reg;
    assign best_z         = best_z_reg[15:0];
    assign depth_sum      = dsum_reg;
    assign confidence_sum = csum_reg;
    assign points_seen    = seen_reg;
    assign inside_count   = inside_reg;

endmodule

[design/depth_frame_nearest_point_stats_unit.sv]
// Top level of the depth frame nearest point statistics unit.
// Takes one depth point per request on the slave stream, tlast on the last point of a
// frame. After the frame's last point s_tready stays low through a start state, two
// passes of the shared one-bit-per-cycle divider (16 quotient steps, then a done strobe;
// mean depth, then mean confidence), then the load of the output register, which waits
// while the previous result is still held there. The result request carries the frame's
// nearest point (first on ties), both means, the count of points inside the box around
// the previous frame's nearest point, the object flag and the point count. The first
// frame's box sits around (0, 0, 0). Points past MAX_FRAME_POINTS in one frame are
// ignored, though their tlast still closes the frame. Counts saturate at 131071.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user must write it
// only while the unit is idle, the block itself does not enforce this.
module depth_frame_nearest_point_stats_unit #(
    parameter int MAX_FRAME_POINTS = 65536
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [dfnps_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dfnps_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Point stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata, low bit up: point_x[15:0], point_y[15:0], point_z[15:0],
    // point_confidence[7:0]
    input  logic [55:0]                         s_tdata,
    input  logic                                s_tlast,     // frame_end
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata, low bit up: nearest_x[15:0], nearest_y[15:0], nearest_z[15:0],
    // mean_depth[15:0], mean_confidence[7:0], box_count[16:0], object_seen,
    // frame_points[16:0], 5 zero bits
    output logic [111:0]                        m_tdata
);
    import dfnps_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_POINTS + 1);
    localparam int WIDE_W = (CNT_W > 17) ? CNT_W : 17;
    localparam int DIV_W = CNT_W + QUOT_W;

    // ---- configuration registers ----
    logic [9:0]  box_half_width_reg;
    logic [10:0] depth_window_reg;
    logic [16:0] object_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_half_width_reg   <= HALF_WIDTH_RESET;
            depth_window_reg     <= WINDOW_RESET;
            object_threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BOX_HALF_WIDTH:   box_half_width_reg   <= cfg_data[9:0];
                CFG_DEPTH_WINDOW:     depth_window_reg     <= cfg_data[10:0];
                CFG_OBJECT_THRESHOLD: object_threshold_reg <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // ---- sequencer control ----
    seq_state_t state_reg, state_next;

    logic s_accept;
    logic acc_clear;
    logic div_start;
    logic div_sel_conf;
    logic out_load;
    logic div_done;
    logic [QUOT_W-1:0] div_quot;

    assign s_accept = s_tvalid && s_tready;

    // ---- frame accumulator ----
    logic signed [15:0] best_x, best_y;
    logic [15:0]        best_z;
    logic [CNT_W+15:0]  depth_sum;
    logic [CNT_W+7:0]   confidence_sum;
    logic [CNT_W-1:0]   points_seen;
    logic [CNT_W-1:0]   inside_count;

    dfnps_accum #(
        .MAX_FRAME_POINTS (MAX_FRAME_POINTS),
        .CNT_W            (CNT_W)
    ) u_accum (
        .clk              (clk),
        .rst_n            (rst_n),
        .take             (s_accept),
        .clear            (acc_clear),
        .point_x          ($signed(s_tdata[15:0])),
        .point_y          ($signed(s_tdata[31:16])),
        .point_z          (s_tdata[47:32]),
        .point_confidence (s_tdata[55:48]),
        .box_half_width   (box_half_width_reg),
        .depth_window     (depth_window_reg),
        .best_x           (best_x),
        .best_y           (best_y),
        .best_z           (best_z),
        .depth_sum        (depth_sum),
        .confidence_sum   (confidence_sum),
        .points_seen      (points_seen),
        .inside_count     (inside_count)
    );

    // ---- shared divider ----
    // Confidence is scaled by 256 so both means come out of the same 16 steps;
    // the mean confidence is the upper quotient byte.
    logic [DIV_W-1:0] div_dividend;

    assign div_dividend = div_sel_conf ? {confidence_sum, 8'd0} : depth_sum;

    dfnps_div #(
        .CNT_W    (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (points_seen),     // never zero at a frame end
        .done     (div_done),
        .quotient (div_quot)
    );

    // ---- next state ----
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_accept && s_tlast)
                    state_next = ST_START;
            ST_START:
                state_next = ST_WAIT_DEPTH;
            ST_WAIT_DEPTH:
                if (div_done)
                    state_next = ST_WAIT_CONF;
            ST_WAIT_CONF:
                if (div_done)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ---- sequencer outputs ----
    logic m_tvalid_reg, m_tvalid_next;

    always_comb
    begin
        s_tready     = 1'b0;
        div_start    = 1'b0;
        div_sel_conf = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE:
                s_tready = 1'b1;
            ST_START:
                div_start = 1'b1;
            ST_WAIT_DEPTH:
            begin
                // conf pass starts as the depth pass finishes
                div_sel_conf = 1'b1;
                div_start    = div_done;
            end
            ST_WAIT_CONF: ;
            ST_EMIT:
                out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    // Frame state is cleared when its result enters the output register
    assign acc_clear = out_load;

    // ---- result assembly ----
    logic [WIDE_W-1:0] inside_wide, seen_wide, thr_wide;
    logic [16:0]       box_count_sat, frame_points_sat;

    assign inside_wide = WIDE_W'(inside_count);
    assign seen_wide   = WIDE_W'(points_seen);
    assign thr_wide    = WIDE_W'(object_threshold_reg);

    assign box_count_sat    = (inside_wide > WIDE_W'(COUNT_MAX)) ? COUNT_MAX
                                                                 : inside_wide[16:0];
    assign frame_points_sat = (seen_wide > WIDE_W'(COUNT_MAX)) ? COUNT_MAX
                                                               : seen_wide[16:0];

    logic [15:0]        mean_depth_hold_reg;
    logic signed [15:0] nearest_x_reg, nearest_y_reg;
    logic [15:0]        nearest_z_reg, mean_depth_reg;
    logic [7:0]         mean_confidence_reg;
    logic [16:0]        box_count_reg, frame_points_reg;
    logic               object_seen_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WAIT_DEPTH && div_done)
            mean_depth_hold_reg <= div_quot;
        if (out_load)
        begin
            nearest_x_reg       <= best_x;
            nearest_y_reg       <= best_y;
            nearest_z_reg       <= best_z;
            mean_depth_reg      <= mean_depth_hold_reg;
            mean_confidence_reg <= div_quot[QUOT_W-1:QUOT_W-8];
            box_count_reg       <= box_count_sat;
            object_seen_reg     <= inside_wide > thr_wide;
            frame_points_reg    <= frame_points_sat;
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, frame_points_reg, object_seen_reg, box_count_reg,
                       mean_confidence_reg, mean_depth_reg, nearest_z_reg,
                       nearest_y_reg, nearest_x_reg};

    // ---- assertions ----
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_WAIT_DEPTH || state_reg == ST_WAIT_CONF))
        else $error("divider finished outside a wait state");

    a_frame_end_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_tlast) |=> !s_tready)
        else $error("point accepted right after a frame end");

    a_points_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> frame_points_reg != 17'd0)
        else $error("result with empty frame");

    a_mean_above_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> mean_depth_reg >= nearest_z_reg)
        else $error("mean depth below nearest depth");

endmodule

[test/tb.sv]
// Testbench for the depth frame nearest point statistics unit.
`timescale 1ns / 100ps

module tb;
    import dfnps_pkg::*;

    // Frame point limit, shared by the unit and the predictor below
    localparam int FRAME_POINT_LIMIT = 65536;
    // Cycles with no request, result or register write before giving up
    localparam int QUIET_LIMIT = 2000;
    // Wait that covers the frame-end path (update, two divider passes, output load)
    localparam int SETTLE_CYCLES = 40;
    // Index with no register behind it; a write there must change nothing
    localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;
    // Points in the long single frame
    localparam int LONG_FRAME_POINTS = 100;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        z;
        logic [7:0]         conf;
        logic               last;
    } point_t;

    typedef struct {
        logic signed [15:0] near_x;
        logic signed [15:0] near_y;
        logic [15:0]        near_z;
        logic [15:0]        mean_z;
        logic [7:0]         mean_conf;
        logic [16:0]        box_hits;
        logic               object_flag;
        logic [16:0]        point_count;
        logic [4:0]         pad;
    } frame_stats_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [55:0]            s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [111:0]           m_tdata;

    // Predictor copy of the registers
    logic [9:0]         half_width;
    logic [10:0]        window;
    logic [16:0]        threshold;
    // Predictor copy of the state: box anchor (last frame's nearest point) and frame sums
    logic signed [15:0] anchor_x;
    logic signed [15:0] anchor_y;
    logic [15:0]        anchor_z;
    logic signed [15:0] lead_x;
    logic signed [15:0] lead_y;
    logic [16:0]        lead_z;
    logic [31:0]        z_total;
    logic [23:0]        conf_total;
    int unsigned        taken;
    int unsigned        boxed;

    frame_stats_t stats_due[$];   // frame results predicted, not yet seen
    int  errors = 0;
    int  points_sent = 0;
    int  frames_done = 0;
    int  settings_used = 0;
    int  quiet_cycles = 0;
    bit  idle_on = 1'b1;          // random gaps on both streams when set

    always #5 clk = ~clk;

    depth_frame_nearest_point_stats_unit #(
        .MAX_FRAME_POINTS(FRAME_POINT_LIMIT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_frame_sums();
        lead_x     = '0;
        lead_y     = '0;
        lead_z     = Z_ABOVE_ANY;
        z_total    = '0;
        conf_total = '0;
        taken      = 0;
        boxed      = 0;
    endfunction

    function automatic void mirror_reset();
        half_width = HALF_WIDTH_RESET;
        window     = WINDOW_RESET;
        threshold  = THRESHOLD_RESET;
        anchor_x   = '0;
        anchor_y   = '0;
        anchor_z   = '0;
        clear_frame_sums();
    endfunction

    function automatic void mirror_write(logic [1:0] idx, logic [16:0] val);
        case (idx)
            CFG_BOX_HALF_WIDTH:   half_width = val[9:0];
            CFG_DEPTH_WINDOW:     window     = val[10:0];
            CFG_OBJECT_THRESHOLD: threshold  = val;
            default:              ;
        endcase
    endfunction

    function automatic logic [16:0] sat_count(int unsigned v);
        return (v > COUNT_MAX) ? COUNT_MAX : v[16:0];
    endfunction

    // Fold one accepted point into the frame; on tlast queue the frame's result
    function automatic void absorb_point(point_t p);
        int           hw;
        int           wi;
        int           px;
        int           py;
        int           pz;
        int           xi;
        int           yi;
        int           zi;
        int unsigned  n;
        frame_stats_t s;
        hw = half_width;
        wi = window;
        px = anchor_x;
        py = anchor_y;
        pz = anchor_z;
        xi = p.x;
        yi = p.y;
        zi = p.z;
        // points past the frame limit are dropped, but their tlast still counts
        if (taken < FRAME_POINT_LIMIT) begin
            if (xi > px - hw && xi < px + hw && yi > py - hw && yi < py + hw &&
                zi > pz && zi < pz + wi)
                boxed++;
            z_total    += p.z;
            conf_total += p.conf;
            if ({1'b0, p.z} < lead_z) begin   // strict: first point wins a tie
                lead_z = {1'b0, p.z};
                lead_x = p.x;
                lead_y = p.y;
            end
            taken++;
        end
        if (p.last) begin
            n             = (taken != 0) ? taken : 1;
            s.near_x      = lead_x;
            s.near_y      = lead_y;
            s.near_z      = lead_z[15:0];
            s.mean_z      = 16'(z_total / n);
            s.mean_conf   = 8'(conf_total / n);
            s.box_hits    = sat_count(boxed);
            s.object_flag = (boxed > threshold);
            s.point_count = sat_count(taken);
            s.pad         = '0;
            stats_due.insert(stats_due.size(), s);
            anchor_x = lead_x;
            anchor_y = lead_y;
            anchor_z = lead_z[15:0];
            clear_frame_sums();
        end
    endfunction

    // ------------------------------------------------------------------
    // Point stream driver and register writes
    // ------------------------------------------------------------------

    task automatic send_point(point_t p);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p.conf, p.z, p.y, p.x};
        s_tlast  <= p.last;
        do @(posedge clk); while (!s_tready);
        absorb_point(p);
        points_sent++;
        if (p.last)
            frames_done++;
    endtask

    // Hold the point stream until every predicted result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (stats_due.size() != 0)
            @(posedge clk);
    endtask

    // Idle point for register writes: all results back, frame-end path finished
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        mirror_write(idx, val);
    endtask

    task automatic apply_setting(int hw, int win, int thr);
        write_reg(CFG_BOX_HALF_WIDTH, 17'(hw));
        write_reg(CFG_DEPTH_WINDOW, 17'(win));
        write_reg(CFG_OBJECT_THRESHOLD, 17'(thr));
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Point generation
    // ------------------------------------------------------------------

    function automatic point_t pt(int x, int y, int z, int c, bit last);
        point_t p;
        p.x    = 16'(x);
        p.y    = 16'(y);
        p.z    = 16'(z);
        p.conf = 8'(c);
        p.last = last;
        return p;
    endfunction

    function automatic logic signed [15:0] clamp_xy(int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic [15:0] clamp_z(int v);
        if (v < 0)
            return 16'd0;
        if (v > 65535)
            return 16'hFFFF;
        return v[15:0];
    endfunction

    // Mostly points scattered around the box edges, some anywhere, a few on corners
    function automatic point_t make_point(bit last);
        point_t p;
        int     hw;
        int     wi;
        int     pick;
        int     off_x;
        int     off_y;
        int     off_z;
        hw   = half_width;
        wi   = window;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            off_x = $urandom_range(0, 2 * hw + 4);
            off_y = $urandom_range(0, 2 * hw + 4);
            off_z = $urandom_range(0, wi + 6);
            p.x   = clamp_xy(int'(anchor_x) + off_x - hw - 2);
            p.y   = clamp_xy(int'(anchor_y) + off_y - hw - 2);
            p.z   = clamp_z(int'(anchor_z) + off_z - 3);
        end else if (pick < 9) begin
            p.x = 16'($urandom);
            p.y = 16'($urandom);
            p.z = 16'($urandom);
        end else begin
            p.x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            p.y = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            p.z = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        p.conf = 8'($urandom);
        p.last = last;
        return p;
    endfunction

    // Whole frames of random length; occasional holds until results are back
    task automatic run_frames(int count);
        int left;
        int len;
        left = count;
        while (left > 0) begin
            idle_on = ($urandom_range(0, 4) != 0);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            if (len > left)
                len = left;
            for (int i = 0; i < len; i++)
                send_point(make_point(i == len - 1));
            left -= len;
            if ($urandom_range(0, 9) == 0)
                drain();
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers: box 100, window 200, threshold 300
    task automatic test_first_frame_box();
        // first frame: box around (0, 0, 0)
        send_point(pt(0, 0, 1, 255, 0));              // inside
        send_point(pt(99, -99, 199, 0, 0));           // inside, at the inner edges
        send_point(pt(100, 0, 50, 10, 0));            // x on the edge: outside
        send_point(pt(-99, 99, 200, 20, 0));          // z at anchor + window: outside
        send_point(pt(5, 5, 0, 30, 0));               // z not above anchor; new nearest
        send_point(pt(7, 7, 0, 40, 0));               // equal depth, earlier point stays
        send_point(pt(-32768, 32767, 65535, 255, 0));
        send_point(pt(32767, -32768, 65535, 255, 1));
        // one-point frame, inside the box around (5, 5, 0)
        send_point(pt(-1, 3, 150, 128, 1));
        // both points at full depth: the first is the nearest
        send_point(pt(-32768, -32768, 65535, 0, 0));
        send_point(pt(32767, 32767, 65535, 255, 1));
        // anchor at full depth: nothing can lie deeper
        send_point(pt(-32767, -32767, 65535, 7, 0));
        send_point(pt(0, 0, 0, 255, 1));
        // back near the origin: box edges from below
        send_point(pt(-99, 99, 1, 1, 0));
        send_point(pt(-100, 0, 100, 2, 0));
        send_point(pt(0, -100, 100, 3, 1));
        drain();
    endtask

    task automatic test_register_extremes();
        int hw_set[6]  = '{0, 1023, 1000, 1, 2, 100};
        int win_set[6] = '{0, 2047, 2000, 1, 3, 200};
        int thr_set[6] = '{0, 131071, 65536, 0, 1, 300};
        for (int k = 0; k < 6; k++) begin
            settle();
            apply_setting(hw_set[k], win_set[k], thr_set[k]);
            if (k == 3)
                write_reg(CFG_SPARE_INDEX, 17'($urandom));
            run_frames(30);
        end
    endtask

    task automatic test_random_traffic();
        int thr;
        for (int k = 0; k < 8; k++) begin
            settle();
            thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071) : $urandom_range(0, 20);
            apply_setting($urandom_range(0, 1023), $urandom_range(0, 2047), thr);
            run_frames(40);
        end
    endtask

    // One long frame, every point inside the box, count one above the threshold
    task automatic test_long_frame();
        settle();
        idle_on = 1'b0;
        apply_setting(1000, 2000, LONG_FRAME_POINTS - 1);
        send_point(pt(0, 0, 100, 0, 1));              // anchor at (0, 0, 100)
        for (int i = 0; i < LONG_FRAME_POINTS; i++)
            send_point(pt($urandom_range(0, 1998) - 999, $urandom_range(0, 1998) - 999,
                          $urandom_range(101, 2099), $urandom_range(0, 255),
                          i == LONG_FRAME_POINTS - 1));
        drain();
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void check_field(string name, logic [16:0] want, logic [16:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                     $time, name, want, want, got, got);
        end
    endfunction

    initial
    begin
        int           stall;
        frame_stats_t want;
        frame_stats_t got;
        wait (rst_n);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 6) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got.near_x      = m_tdata[15:0];
            got.near_y      = m_tdata[31:16];
            got.near_z      = m_tdata[47:32];
            got.mean_z      = m_tdata[63:48];
            got.mean_conf   = m_tdata[71:64];
            got.box_hits    = m_tdata[88:72];
            got.object_flag = m_tdata[89];
            got.point_count = m_tdata[106:90];
            got.pad         = m_tdata[111:107];
            if (stats_due.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected, expected nothing, actual 0x%0h",
                         $time, m_tdata);
            end
            else
            begin
                want = stats_due.pop_front();
                check_field("nearest_x", 17'(want.near_x), 17'(got.near_x));
                check_field("nearest_y", 17'(want.near_y), 17'(got.near_y));
                check_field("nearest_z", 17'(want.near_z), 17'(got.near_z));
                check_field("mean_depth", 17'(want.mean_z), 17'(got.mean_z));
                check_field("mean_confidence", 17'(want.mean_conf), 17'(got.mean_conf));
                check_field("box_count", want.box_hits, got.box_hits);
                check_field("object_seen", 17'(want.object_flag), 17'(got.object_flag));
                check_field("frame_points", want.point_count, got.point_count);
                check_field("padding", 17'(want.pad), 17'(got.pad));
            end
        end
    end

    // Watchdog: a stretch with no request, result or register write means a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d results outstanding",
                         $time, QUIET_LIMIT, stats_due.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        mirror_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_frame_box();
        test_register_extremes();
        test_random_traffic();
        test_long_frame();

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d points in %0d frames under %0d register settings,",
                 points_sent, frames_done, settings_used);
        $display("with box edges, register extremes and a %0d-point frame; %0d mismatches.",
                 LONG_FRAME_POINTS, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
design/dfnps_pkg.sv
design/dfnps_div.sv
design/dfnps_accum.sv
design/depth_frame_nearest_point_stats_unit.sv
test/tb.sv
